// ===== hw/rtl/nmb_pkg.sv =====
// shared constants, payload types and register codes of the neighbour mean blur
package nmb_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W      = $clog2(MAX_HEIGHT + 1);
  localparam int SIZE_W      = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_W     = 11;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int PIX_W       = NUM_CHAN * CHAN_W;
  localparam int SUM_W       = CHAN_W + 3;
  localparam int MIN_SIZE    = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  blue_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  red_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_last;
  } pix_out_t;

  // one classified item handed from front to back
  typedef struct packed {
    pix_in_t            pix;
    logic [COL_W-1:0]   col;
    logic               emit;
    logic [COORD_W-1:0] res_row;
    logic [COORD_W-1:0] res_col;
    logic               last;
  } q_item_t;

endpackage

// ===== hw/rtl/nmb_front.sv =====
// front end: size registers, raster position counters and item classification
module nmb_front import nmb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pix_in_t              in_data_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output q_item_t              q_item_o
);

  logic [SIZE_W-1:0] width_q, width_d, height_q, height_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [WEFF_W-1:0] w_eff;
  logic [HEFF_W-1:0] h_eff;
  logic              last_col, last_row, accept;

  always_comb begin
    if (32'(width_q) < MIN_SIZE) begin
      w_eff = WEFF_W'(MIN_SIZE);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    if (32'(height_q) < MIN_SIZE) begin
      h_eff = HEFF_W'(MIN_SIZE);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(height_q);
    end
  end

  assign last_col   = (WEFF_W'(col_q) == w_eff - WEFF_W'(1));
  assign last_row   = (HEFF_W'(row_q) == h_eff - HEFF_W'(1));
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    q_item_o.pix     = in_data_i;
    q_item_o.col     = col_q;
    q_item_o.emit    = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
    q_item_o.res_row = COORD_W'(row_q - ROW_W'(1));
    q_item_o.res_col = COORD_W'(col_q - COL_W'(1));
    q_item_o.last    = last_col && last_row;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_valid_i) begin
      // any write restarts the frame, unknown indices included
      col_d = '0;
      row_d = '0;
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        REG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

// ===== hw/rtl/nmb_queue.sv =====
// short in-order queue of classified items between front and back
module nmb_queue import nmb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t head_o
);

  q_item_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? QPTR_W'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH) : wr_ptr_q;
    rd_ptr_d = do_pop ? QPTR_W'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/nmb_back.sv =====
// back end: line store, 3x3 window, neighbour sums and output register
module nmb_back import nmb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  q_item_t  q_head_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o
);

  // each entry holds {row r-2, row r-1} for one column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd_q;
  q_item_t            s1_item_q;
  logic               s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0]   win_q [6];
  logic               out_valid_q, out_valid_d;
  pix_out_t           out_data_q, out_data_d;
  logic [PIX_W-1:0]   pix_a, pix_b, pix_x;
  logic [PIX_W-1:0]   mean;
  logic               s1_adv;

  assign pix_a = line_rd_q[2*PIX_W-1:PIX_W];
  assign pix_b = line_rd_q[PIX_W-1:0];
  assign pix_x = {s1_item_q.pix.red_in, s1_item_q.pix.green_in, s1_item_q.pix.blue_in};

  assign s1_adv  = s1_valid_q && (!s1_item_q.emit || !out_valid_q || out_ready_i);
  assign q_pop_o = q_valid_i && (!s1_valid_q || s1_adv);

  // centre entry win_q[1] is left out of the sum
  always_comb begin
    logic [SUM_W-1:0] s;
    for (int k = 0; k < NUM_CHAN; k++) begin
      s = SUM_W'(win_q[3][k*CHAN_W +: CHAN_W]) + SUM_W'(win_q[4][k*CHAN_W +: CHAN_W])
        + SUM_W'(win_q[5][k*CHAN_W +: CHAN_W]) + SUM_W'(win_q[0][k*CHAN_W +: CHAN_W])
        + SUM_W'(win_q[2][k*CHAN_W +: CHAN_W]) + SUM_W'(pix_a[k*CHAN_W +: CHAN_W])
        + SUM_W'(pix_b[k*CHAN_W +: CHAN_W]) + SUM_W'(pix_x[k*CHAN_W +: CHAN_W]);
      mean[k*CHAN_W +: CHAN_W] = s[SUM_W-1:3];
    end
  end

  always_comb begin
    s1_valid_d = q_pop_o ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_data_d = out_data_q;
    if (s1_adv && s1_item_q.emit) begin
      out_valid_d           = 1'b1;
      out_data_d.blue_out   = mean[0*CHAN_W +: CHAN_W];
      out_data_d.green_out  = mean[1*CHAN_W +: CHAN_W];
      out_data_d.red_out    = mean[2*CHAN_W +: CHAN_W];
      out_data_d.out_row    = s1_item_q.res_row;
      out_data_d.out_col    = s1_item_q.res_col;
      out_data_d.frame_last = s1_item_q.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // read on pop, write back when the item leaves the stage
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      line_rd_q <= line_mem[q_head_i.col];
      s1_item_q <= q_head_i;
    end
    if (s1_adv) begin
      line_mem[s1_item_q.col] <= {pix_b, pix_x};
    end
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        win_q[3] <= win_q[0];
        win_q[4] <= win_q[1];
        win_q[5] <= win_q[2];
        win_q[0] <= pix_a;
        win_q[1] <= pix_b;
        win_q[2] <= pix_x;
      end
    end
  end

endmodule

// ===== hw/rtl/neighbour_mean_blur_3x3_core.sv =====
// top level of the 3x3 neighbour mean blur: front, queue and back
//
//   channel   direction   handshake                 payload
//   in        input       in_valid_i / in_ready_o   in_data_i   (pix_in_t)
//   out       output      out_valid_o / out_ready_i out_data_o  (pix_out_t)
//   cfg       input       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one pixel per clock sustained while out is not stalled; a result shows on out
// after the pixel that completes its window passes the queue, then the line
// store read stage, then the output register
// the line store is one 1w1r memory, read when an item leaves the queue and
// written when it leaves the read stage; its contents are not cleared at reset
// a stalled output holds the back stage, the queue then fills and drops in_ready_o
// cfg writes are always taken and restart the frame at row 0, column 0
module neighbour_mean_blur_3x3_core import nmb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pix_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  logic    q_full, q_push, q_pop, q_valid;
  q_item_t q_in_item, q_head;

  assign cfg_ready_o = 1'b1;

  nmb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in_item)
  );

  nmb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  nmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/nmb_checker.sv =====
// port level checks of the neighbour mean blur, bound to the top level
module nmb_checker import nmb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input pix_out_t out_data_o,
  input logic     cfg_ready_o
);

  // no result is left over from before reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("out_valid_o high during reset");

  // results only for interior pixels; checked against row 0 and column 0
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_row != '0) && (out_data_o.out_col != '0))
    else $error("result for a border pixel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg port not ready");

endmodule

bind neighbour_mean_blur_3x3_core nmb_checker u_nmb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
